/* sv/utpc_pkg.sv */
// Shared constants, status codes and the packet record type for the UDP test packet checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package utpc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PORT_W        = 16;
  localparam int unsigned VB_W          = 3;
  localparam int unsigned LEN_W         = 14;
  localparam int unsigned LEN_MAX       = (1 << LEN_W) - 1;
  localparam int unsigned SEQ_LIM_W     = 17;
  localparam int unsigned MIN_PKT_BYTES = 16;
  localparam int unsigned HDR_LEN_END   = 4;
  localparam int unsigned HDR_SEQ_END   = 8;
  localparam int unsigned BYTES_PER_WORD = 4;

  localparam int unsigned CLIENT_SLOTS  = 16;
  localparam int unsigned SLOT_W        = $clog2(CLIENT_SLOTS);
  localparam int unsigned SEQ_SLOTS     = 65536;
  localparam int unsigned SEQ_W         = $clog2(SEQ_SLOTS);

  localparam int unsigned SEEN_WORD_W   = 16;
  localparam int unsigned BIT_W         = $clog2(SEEN_WORD_W);
  localparam int unsigned ROW_W         = SLOT_W + SEQ_W - BIT_W;
  localparam int unsigned SEEN_ROWS     = 1 << ROW_W;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 17;

  localparam logic [LEN_W-1:0]     MAX_LEN_RESET   = LEN_W'(1400);
  localparam logic [SEQ_LIM_W-1:0] SEQ_LIMIT_RESET = SEQ_LIM_W'(65536);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TABLE_FULL   = 3'd1,
    ST_BAD_SIZE     = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_SEQ_RANGE    = 3'd4,
    ST_DUPLICATE    = 3'd5,
    ST_CONTENT      = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN   = 1'b0,
    CFG_SEQ_LIMIT = 1'b1
  } cfg_reg_e;

  // ST_OK here means the seen map still decides the outcome
  typedef struct packed {
    status_e               pre_status;
    logic                  perr;
    logic [SLOT_W-1:0]     slot;
    logic [DATA_W-1:0]     seq;
    logic [LEN_W-1:0]      length;
  } pkt_rec_t;

endpackage

/* sv/udp_test_packet_checker.sv */
// Top level of the UDP test packet checker: front end, record queue, back end.
// Depends on utpc_pkg, utpc_front, utpc_queue, utpc_back.
//
// Takes one packet word per clock cycle while in_ready_o is high. A packet's record passes a
// four-entry record queue (input goes on while results wait), the lookup stage and the result
// register. Input stalls when the queue fills or while the seen map (SEEN_ROWS = 65536 rows of
// 16 bits) is zeroed after reset, one row per cycle; configuration writes are still taken then.
// The client lookup compares all 16 slots in the cycle of the first word; the back end reads
// one seen-map row and writes one row a cycle, one packet a cycle unless output stalls.
// Configuration must be written only while the block is idle; the block does not check this.
`timescale 1ns / 1ps

module udp_test_packet_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [utpc_pkg::DATA_W-1:0]     client_ip_i,
  input  logic [utpc_pkg::PORT_W-1:0]     client_port_i,
  input  logic [utpc_pkg::DATA_W-1:0]     data_word_i,
  input  logic                            first_word_i,
  input  logic                            last_word_i,
  input  logic [utpc_pkg::VB_W-1:0]       valid_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [utpc_pkg::SLOT_W-1:0]     client_slot_o,
  output logic [utpc_pkg::DATA_W-1:0]     sequence_number_o,
  output logic [utpc_pkg::LEN_W-1:0]      received_length_o,
  output logic [utpc_pkg::DATA_W-1:0]     client_packet_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [utpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [utpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import utpc_pkg::*;

  logic     acc;
  logic     push;
  pkt_rec_t push_rec;
  logic     q_vld;
  logic     q_full;
  logic     q_pop;
  pkt_rec_t q_rec;
  logic     clr_busy;

  assign in_ready_o  = !q_full && !clr_busy;
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  utpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .client_ip_i   (client_ip_i),
    .client_port_i (client_port_i),
    .data_word_i   (data_word_i),
    .first_word_i  (first_word_i),
    .last_word_i   (last_word_i),
    .valid_bytes_i (valid_bytes_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  utpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .full_o (q_full),
    .rec_o  (q_rec)
  );

  utpc_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_vld_i               (q_vld),
    .q_rec_i               (q_rec),
    .q_pop_o               (q_pop),
    .clr_busy_o            (clr_busy),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .client_slot_o         (client_slot_o),
    .sequence_number_o     (sequence_number_o),
    .received_length_o     (received_length_o),
    .client_packet_count_o (client_packet_count_o)
  );

endmodule

/* sv/utpc_front.sv */
// Front end: client slot lookup, per-word header/payload tracking, early packet classification.
// Depends on utpc_pkg.
`timescale 1ns / 1ps

module utpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [utpc_pkg::DATA_W-1:0]     client_ip_i,
  input  logic [utpc_pkg::PORT_W-1:0]     client_port_i,
  input  logic [utpc_pkg::DATA_W-1:0]     data_word_i,
  input  logic                            first_word_i,
  input  logic                            last_word_i,
  input  logic [utpc_pkg::VB_W-1:0]       valid_bytes_i,
  input  logic                            cfg_we_i,
  input  logic [utpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [utpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            push_o,
  output utpc_pkg::pkt_rec_t              rec_o
);
  import utpc_pkg::*;

  logic [LEN_W-1:0]     max_len_q;
  logic [SEQ_LIM_W-1:0] seq_lim_q;

  logic [DATA_W-1:0] slot_ip_q   [CLIENT_SLOTS];
  logic [PORT_W-1:0] slot_port_q [CLIENT_SLOTS];
  logic [SLOT_W:0]   used_cnt_q;

  logic              open_q;
  logic [LEN_W-1:0]  cnt_q;
  logic              ovf_q;
  logic [DATA_W-1:0] hlen_q;
  logic [DATA_W-1:0] seq_q;
  logic              perr_q;
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;

  logic              match_any;
  logic [SLOT_W-1:0] match_idx;
  logic              alloc;
  logic              lk_full;
  logic [SLOT_W-1:0] lk_slot;

  logic              take;
  logic [VB_W-1:0]   nb;
  logic [DATA_W-1:0] mask;
  logic [LEN_W-1:0]  off;
  logic              ovf_b;
  logic [DATA_W-1:0] seq_b;
  logic [SLOT_W-1:0] slot_b;
  logic              full_b;
  logic [LEN_W:0]    sum;

  logic [LEN_W-1:0]  cnt_d;
  logic              ovf_d;
  logic [DATA_W-1:0] hlen_d;
  logic [DATA_W-1:0] seq_d;
  logic              perr_d;
  status_e           pre_status;

  // lowest matching used slot
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (((SLOT_W+1)'(i) < used_cnt_q) && (slot_ip_q[i] == client_ip_i) &&
          (slot_port_q[i] == client_port_i)) begin
        match_any = 1'b1;
        match_idx = SLOT_W'(i);
      end
    end
  end

  assign alloc   = !match_any && (used_cnt_q != (SLOT_W+1)'(CLIENT_SLOTS));
  assign lk_full = !match_any && !alloc;
  assign lk_slot = match_any ? match_idx : (alloc ? used_cnt_q[SLOT_W-1:0] : '0);

  assign take = acc_i && (first_word_i || open_q);

  always_comb begin
    case (valid_bytes_i)
      3'd0:                nb = '0;
      3'd1, 3'd2, 3'd3:    nb = valid_bytes_i;
      default:             nb = VB_W'(BYTES_PER_WORD);
    endcase
  end

  always_comb begin
    case (nb)
      3'd0:    mask = '0;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = '1;
    endcase
  end

  always_comb begin
    off    = first_word_i ? '0    : cnt_q;
    ovf_b  = first_word_i ? 1'b0  : ovf_q;
    hlen_d = first_word_i ? '0    : hlen_q;
    seq_b  = first_word_i ? '0    : seq_q;
    perr_d = first_word_i ? 1'b0  : perr_q;
    slot_b = first_word_i ? lk_slot : slot_q;
    full_b = first_word_i ? lk_full : full_q;
    seq_d  = seq_b;
    if ((nb != '0) && !ovf_b) begin
      if (off < LEN_W'(HDR_LEN_END)) begin
        hlen_d = data_word_i & mask;
      end else if (off < LEN_W'(HDR_SEQ_END)) begin
        seq_d = data_word_i & mask;
      end else if ((off >= LEN_W'(MIN_PKT_BYTES)) && (((data_word_i ^ seq_b) & mask) != '0)) begin
        perr_d = 1'b1;
      end
    end
    sum = {1'b0, off} + (LEN_W+1)'(nb);
    if (sum > (LEN_W+1)'(LEN_MAX)) begin
      cnt_d = LEN_W'(LEN_MAX);
      ovf_d = 1'b1;
    end else begin
      cnt_d = sum[LEN_W-1:0];
      ovf_d = ovf_b;
    end
  end

  always_comb begin
    if (full_b) begin
      pre_status = ST_TABLE_FULL;
    end else if (ovf_d || (cnt_d < LEN_W'(MIN_PKT_BYTES)) || (cnt_d > max_len_q)) begin
      pre_status = ST_BAD_SIZE;
    end else if (hlen_d != DATA_W'(cnt_d)) begin
      pre_status = ST_LEN_MISMATCH;
    end else if ((seq_d >= DATA_W'(seq_lim_q)) || ((seq_d >> SEQ_W) != '0)) begin
      pre_status = ST_SEQ_RANGE;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign push_o            = take && last_word_i;
  assign rec_o.pre_status  = pre_status;
  assign rec_o.perr        = perr_d;
  assign rec_o.slot        = slot_b;
  assign rec_o.seq         = seq_d;
  assign rec_o.length      = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MAX_LEN_RESET;
      seq_lim_q  <= SEQ_LIMIT_RESET;
      used_cnt_q <= '0;
      open_q     <= 1'b0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      hlen_q     <= '0;
      seq_q      <= '0;
      perr_q     <= 1'b0;
      slot_q     <= '0;
      full_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MAX_LEN:   max_len_q <= cfg_data_i[LEN_W-1:0];
          CFG_SEQ_LIMIT: seq_lim_q <= cfg_data_i[SEQ_LIM_W-1:0];
          default:       ;
        endcase
      end
      if (acc_i && first_word_i && alloc) begin
        used_cnt_q <= used_cnt_q + 1'b1;
      end
      if (take) begin
        open_q <= !last_word_i;
        cnt_q  <= cnt_d;
        ovf_q  <= ovf_d;
        hlen_q <= hlen_d;
        seq_q  <= seq_d;
        perr_q <= perr_d;
        slot_q <= slot_b;
        full_q <= full_b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && first_word_i && alloc) begin
      slot_ip_q[used_cnt_q[SLOT_W-1:0]]   <= client_ip_i;
      slot_port_q[used_cnt_q[SLOT_W-1:0]] <= client_port_i;
    end
  end

endmodule

/* sv/utpc_queue.sv */
// Small register FIFO of packet records between front and back end.
// Depends on utpc_pkg.
`timescale 1ns / 1ps

module utpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  utpc_pkg::pkt_rec_t rec_i,
  input  logic               pop_i,
  output logic               vld_o,
  output logic               full_o,
  output utpc_pkg::pkt_rec_t rec_o
);
  import utpc_pkg::*;

  pkt_rec_t          ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign vld_o  = (cnt_q != '0);
  assign full_o = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rec_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= rec_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> vld_o)
    else $error("queue pop while empty");

endmodule

/* sv/utpc_back.sv */
// Back end: seen-map lookup and update, per-client good counters, result register.
// Depends on utpc_pkg; holds the seen-map memory and its clearing pass.
`timescale 1ns / 1ps

module utpc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_vld_i,
  input  utpc_pkg::pkt_rec_t            q_rec_i,
  output logic                          q_pop_o,
  output logic                          clr_busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [utpc_pkg::SLOT_W-1:0]   client_slot_o,
  output logic [utpc_pkg::DATA_W-1:0]   sequence_number_o,
  output logic [utpc_pkg::LEN_W-1:0]    received_length_o,
  output logic [utpc_pkg::DATA_W-1:0]   client_packet_count_o
);
  import utpc_pkg::*;

  logic [SEEN_WORD_W-1:0] seen_mem_q [SEEN_ROWS];
  logic [SEEN_WORD_W-1:0] rd_q;

  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_addr_q;

  logic             a_vld_q;
  pkt_rec_t         a_rec_q;
  logic             a_fwd_q;
  logic [SEEN_WORD_W-1:0] a_fwd_data_q;

  logic [DATA_W-1:0] good_cnt_q [CLIENT_SLOTS];

  logic              out_vld_q;
  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [DATA_W-1:0] out_seq_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [DATA_W-1:0] out_cnt_q;

  logic                   a_adv;
  logic                   pop;
  logic [ROW_W-1:0]       a_row;
  logic [ROW_W-1:0]       q_row;
  logic [BIT_W-1:0]       a_bit;
  logic [SEEN_WORD_W-1:0] row_data;
  logic [SEEN_WORD_W-1:0] item_wdata;
  logic                   item_we;
  status_e                status;
  logic                   good;
  logic [DATA_W-1:0]      cnt_new;

  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [SEEN_WORD_W-1:0] mem_wdata;

  assign a_adv   = a_vld_q && (!out_vld_q || out_ready_i);
  assign pop     = q_vld_i && !clr_busy_q && (!a_vld_q || a_adv);
  assign q_pop_o = pop;

  assign a_row = {a_rec_q.slot, a_rec_q.seq[SEQ_W-1:BIT_W]};
  assign q_row = {q_rec_i.slot, q_rec_i.seq[SEQ_W-1:BIT_W]};
  assign a_bit = a_rec_q.seq[BIT_W-1:0];

  // row read at load time may miss the write of the item just ahead
  assign row_data = a_fwd_q ? a_fwd_data_q : rd_q;

  always_comb begin
    if (a_rec_q.pre_status != ST_OK) begin
      status = a_rec_q.pre_status;
    end else if (row_data[a_bit]) begin
      status = ST_DUPLICATE;
    end else if (a_rec_q.perr) begin
      status = ST_CONTENT;
    end else begin
      status = ST_OK;
    end
  end

  assign good       = (status == ST_OK);
  assign cnt_new    = good_cnt_q[a_rec_q.slot] + DATA_W'(good);
  assign item_we    = a_adv && good;
  assign item_wdata = row_data | (SEEN_WORD_W'(1) << a_bit);

  assign mem_we    = clr_busy_q || item_we;
  assign mem_waddr = clr_busy_q ? clr_addr_q : a_row;
  assign mem_wdata = clr_busy_q ? '0 : item_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem_q[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_q <= seen_mem_q[q_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      a_vld_q    <= 1'b0;
      a_fwd_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        good_cnt_q[i] <= '0;
      end
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == ROW_W'(SEEN_ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (pop) begin
        a_vld_q <= 1'b1;
        a_fwd_q <= item_we && (a_row == q_row);
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
        a_fwd_q <= 1'b0;
      end
      if (item_we) begin
        good_cnt_q[a_rec_q.slot] <= cnt_new;
      end
      if (a_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_rec_q      <= q_rec_i;
      a_fwd_data_q <= item_wdata;
    end
    if (a_adv) begin
      out_status_q <= status;
      out_slot_q   <= a_rec_q.slot;
      out_seq_q    <= a_rec_q.seq;
      out_len_q    <= a_rec_q.length;
      out_cnt_q    <= (status == ST_TABLE_FULL) ? '0 : cnt_new;
    end
  end

  assign clr_busy_o            = clr_busy_q;
  assign out_valid_o           = out_vld_q;
  assign status_o              = out_status_q;
  assign client_slot_o         = out_slot_q;
  assign sequence_number_o     = out_seq_q;
  assign received_length_o     = out_len_q;
  assign client_packet_count_o = out_cnt_q;

  a_no_item_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !a_vld_q)
    else $error("packet in flight during seen-map clear");

  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_addr_q) == ROW_W'(SEEN_ROWS - 1)))
    else $error("seen-map clear ended early");

  a_fwd_only_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fwd_q |-> a_vld_q)
    else $error("row forward flag without request");

  a_full_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q == ST_TABLE_FULL)) |-> ((out_slot_q == '0) && (out_cnt_q == '0)))
    else $error("table-full result carries slot or count");

endmodule

/* dv/udp_test_packet_checker_test.sv */
// Self-checking testbench for udp_test_packet_checker: directed packets, register extremes,
// output back-pressure, random traffic and a full table, each report compared to a local model.
// Depends on utpc_pkg and the udp_test_packet_checker RTL.
`timescale 1ns / 1ps

module udp_test_packet_checker_test;
  import utpc_pkg::*;

  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    logic [DATA_W-1:0] ip;
    logic [PORT_W-1:0] port;
  } sender_t;

  typedef struct {
    logic [DATA_W-1:0] ip;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] data;
    logic              first_w;
    logic              last_w;
    logic [VB_W-1:0]   vb;
  } packet_word_t;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  seq;
    logic [LEN_W-1:0]   length;
    logic [DATA_W-1:0]  count;
  } pkt_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [DATA_W-1:0]     client_ip_i;
  logic [PORT_W-1:0]     client_port_i;
  logic [DATA_W-1:0]     data_word_i;
  logic                  first_word_i;
  logic                  last_word_i;
  logic [VB_W-1:0]       valid_bytes_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [2:0]            status_o;
  logic [SLOT_W-1:0]     client_slot_o;
  logic [DATA_W-1:0]     sequence_number_o;
  logic [LEN_W-1:0]      received_length_o;
  logic [DATA_W-1:0]     client_packet_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  udp_test_packet_checker i_dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic [DATA_W-1:0]    slot_ip_q   [CLIENT_SLOTS];
  logic [PORT_W-1:0]    slot_port_q [CLIENT_SLOTS];
  bit                   slot_used_q [CLIENT_SLOTS];
  logic [DATA_W-1:0]    slot_good_q [CLIENT_SLOTS];
  bit                   seen_map_q  [int unsigned];
  int unsigned          byte_cnt_q;
  logic [DATA_W-1:0]    hdr_len_q;
  logic [DATA_W-1:0]    hdr_seq_q;
  int unsigned          cur_slot_q;
  bit                   perr_q;
  bit                   pkt_open_q;
  bit                   tbl_full_q;
  bit                   len_ovf_q;
  logic [LEN_W-1:0]     max_len_q = MAX_LEN_RESET;
  logic [SEQ_LIM_W-1:0] seq_lim_q = SEQ_LIMIT_RESET;

  pkt_report_t expected_reports[$];
  sender_t     sender_pool[POOL_SIZE];

  int unsigned send_idle_pct    = 0;
  int unsigned recv_idle_pct    = 0;
  int unsigned recv_hold_cycles = 0;
  int unsigned words_sent       = 0;
  int unsigned reports_checked  = 0;
  int unsigned mismatches       = 0;
  int unsigned status_seen[8];

  function automatic logic [31:0] byte_keep_mask(input int unsigned nb);
    if (nb >= BYTES_PER_WORD) return '1;
    return (32'd1 << (8 * nb)) - 32'd1;
  endfunction

  task automatic lookup_sender(input logic [DATA_W-1:0] ip, input logic [PORT_W-1:0] port);
    tbl_full_q = 1'b1;
    cur_slot_q = 0;
    for (int i = 0; i < CLIENT_SLOTS && tbl_full_q; i++) begin
      if (!slot_used_q[i]) begin
        slot_used_q[i] = 1'b1;
        slot_ip_q[i]   = ip;
        slot_port_q[i] = port;
        slot_good_q[i] = '0;
        cur_slot_q     = i;
        tbl_full_q     = 1'b0;
      end else if (slot_ip_q[i] == ip && slot_port_q[i] == port) begin
        cur_slot_q = i;
        tbl_full_q = 1'b0;
      end
    end
  endtask

  task automatic predict_packet_word(input packet_word_t w);
    int unsigned nb;
    int unsigned sum;
    int unsigned seen_idx;
    logic [31:0] mask;
    status_e     st;
    pkt_report_t r;
    seen_idx = 0;
    if (w.first_w) begin
      byte_cnt_q = 0;
      hdr_len_q  = '0;
      hdr_seq_q  = '0;
      perr_q     = 1'b0;
      len_ovf_q  = 1'b0;
      pkt_open_q = 1'b1;
      lookup_sender(w.ip, w.port);
    end else if (!pkt_open_q) begin
      return;
    end
    nb   = (w.vb > BYTES_PER_WORD) ? BYTES_PER_WORD : w.vb;
    mask = byte_keep_mask(nb);
    if (nb != 0 && !len_ovf_q) begin
      if (byte_cnt_q < HDR_LEN_END) begin
        hdr_len_q = w.data & mask;
      end else if (byte_cnt_q < HDR_SEQ_END) begin
        hdr_seq_q = w.data & mask;
      end else if (byte_cnt_q >= MIN_PKT_BYTES && ((w.data ^ hdr_seq_q) & mask) != 0) begin
        perr_q = 1'b1;
      end
    end
    sum = byte_cnt_q + nb;
    if (sum > LEN_MAX) begin
      sum       = LEN_MAX;
      len_ovf_q = 1'b1;
    end
    byte_cnt_q = sum;
    if (!w.last_w) return;
    pkt_open_q = 1'b0;

    if (tbl_full_q) begin
      st = ST_TABLE_FULL;
    end else if (len_ovf_q || byte_cnt_q < MIN_PKT_BYTES || byte_cnt_q > max_len_q) begin
      st = ST_BAD_SIZE;
    end else if (hdr_len_q != 32'(byte_cnt_q)) begin
      st = ST_LEN_MISMATCH;
    end else if (hdr_seq_q >= 32'(seq_lim_q) || hdr_seq_q >= SEQ_SLOTS) begin
      st = ST_SEQ_RANGE;
    end else begin
      seen_idx = cur_slot_q * SEQ_SLOTS + hdr_seq_q;
      if (seen_map_q.exists(seen_idx)) st = ST_DUPLICATE;
      else if (perr_q) st = ST_CONTENT;
      else st = ST_OK;
    end
    if (st == ST_OK) begin
      seen_map_q[seen_idx]    = 1'b1;
      slot_good_q[cur_slot_q] = slot_good_q[cur_slot_q] + 32'd1;
    end

    r.status = st;
    r.slot   = tbl_full_q ? '0 : SLOT_W'(cur_slot_q);
    r.seq    = hdr_seq_q;
    r.length = LEN_W'(byte_cnt_q);
    r.count  = tbl_full_q ? '0 : slot_good_q[cur_slot_q];
    expected_reports.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : report_check
    pkt_report_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, status %0d slot %0d seq %0h len %0d count %0d",
                 $time, status_o, client_slot_o, sequence_number_o, received_length_o,
                 client_packet_count_o);
        mismatches++;
      end else begin
        exp_r = expected_reports.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("client_slot", exp_r.slot, client_slot_o);
        check_field("sequence_number", exp_r.seq, sequence_number_o);
        check_field("received_length", exp_r.length, received_length_o);
        check_field("client_packet_count", exp_r.count, client_packet_count_o);
        reports_checked++;
        status_seen[int'(exp_r.status)]++;
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic send_word(input packet_word_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    client_ip_i   <= w.ip;
    client_port_i <= w.port;
    data_word_i   <= w.data;
    first_word_i  <= w.first_w;
    last_word_i   <= w.last_w;
    valid_bytes_i <= w.vb;
    // hold the request until accepted
    do @(posedge clk_i); while (!in_ready_o);
    predict_packet_word(w);
  endtask

  task automatic send_noise_word();
    packet_word_t w;
    w.ip      = $urandom;
    w.port    = PORT_W'($urandom);
    w.data    = $urandom;
    w.first_w = 1'b0;
    w.last_w  = 1'($urandom);
    w.vb      = VB_W'($urandom);
    send_word(w);
  endtask

  // cut != 0 stops after that many words without a last word
  task automatic send_packet(input sender_t s, input int unsigned nbytes,
                             input logic [31:0] hdr, input logic [31:0] seq,
                             input bit corrupt, input bit ragged, input int unsigned cut);
    int unsigned off;
    int unsigned eff;
    int unsigned k;
    int unsigned bad_at;
    int unsigned bad_bit;
    logic [31:0] keep;
    packet_word_t w;
    off    = 0;
    k      = 0;
    bad_at = (nbytes > MIN_PKT_BYTES) ? $urandom_range(nbytes - 1, MIN_PKT_BYTES) : nbytes;
    while (off < nbytes && !(cut != 0 && k == cut)) begin
      w.vb = ragged ? VB_W'($urandom_range(7, 0)) : VB_W'(BYTES_PER_WORD);
      if (!ragged && nbytes - off < BYTES_PER_WORD) w.vb = VB_W'(nbytes - off);
      eff       = (w.vb > BYTES_PER_WORD) ? BYTES_PER_WORD : w.vb;
      w.first_w = (k == 0);
      w.last_w  = (off + eff >= nbytes);
      w.ip      = w.first_w ? s.ip : $urandom;
      w.port    = w.first_w ? s.port : PORT_W'($urandom);
      if (off < HDR_LEN_END) w.data = hdr;
      else if (off < HDR_SEQ_END) w.data = seq;
      else if (off < MIN_PKT_BYTES) w.data = $urandom;
      else w.data = seq;
      keep   = byte_keep_mask(eff);
      w.data = (w.data & keep) | ($urandom & ~keep);
      if (corrupt && eff != 0 && bad_at >= off && bad_at < off + eff) begin
        bad_bit = 8 * (bad_at - off) + $urandom_range(7, 0);
        w.data[bad_bit] = ~w.data[bad_bit];
      end
      send_word(w);
      off += eff;
      k++;
    end
    words_sent += k;
  endtask

  function automatic sender_t fresh_sender();
    sender_t s;
    s.ip   = $urandom;
    s.port = PORT_W'($urandom);
    return s;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned p;
    int unsigned ml;
    p  = $urandom_range(99, 0);
    ml = max_len_q;
    if (p < 84) return $urandom_range(64, MIN_PKT_BYTES);
    if (p < 92) return $urandom_range(MIN_PKT_BYTES - 1, 1);
    if (p < 97 && ml <= 2048 && ml >= 8) return $urandom_range(ml + 4, ml - 4);
    return $urandom_range(400, 65);
  endfunction

  function automatic logic [31:0] pick_seq();
    int unsigned lim;
    int unsigned p;
    lim = seq_lim_q;
    p   = $urandom_range(99, 0);
    if (lim == 0) return $urandom_range(47, 0);
    if (p < 75) return $urandom_range((lim > 48) ? 47 : lim - 1, 0);
    if (p < 88) return lim - 1;
    return $urandom_range(lim - 1, 0);
  endfunction

  task automatic send_random_packet(input sender_t s);
    int unsigned nbytes;
    int unsigned pick;
    int unsigned cut;
    logic [31:0] hdr;
    logic [31:0] seq;
    bit corrupt;
    bit ragged;
    nbytes  = pick_size();
    seq     = pick_seq();
    hdr     = nbytes;
    corrupt = 1'b0;
    ragged  = 1'b0;
    cut     = 0;
    pick    = $urandom_range(99, 0);
    if (pick < 10) begin
      case ($urandom_range(2, 0))
        0: hdr = nbytes + 1;
        1: hdr = nbytes - 1;
        default: hdr = $urandom;
      endcase
    end else if (pick < 18) begin
      if ($urandom_range(1, 0) == 1) seq = $urandom;
      else seq = 32'(seq_lim_q) + $urandom_range(3, 0);
    end else if (pick < 26) begin
      corrupt = 1'b1;
    end else if (pick < 33) begin
      ragged = 1'b1;
    end else if (pick < 37) begin
      cut = $urandom_range(5, 1);
    end
    send_packet(s, nbytes, hdr, seq, corrupt, ragged, cut);
    if (cut != 0) send_packet(s, nbytes, nbytes, seq, 1'b0, 1'b0, 0);
  endtask

  task automatic wait_all_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int c = 0; c < 200000 && expected_reports.size() != 0; c++) @(posedge clk_i);
    // packets abandoned without a report may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAX_LEN) max_len_q = value[LEN_W-1:0];
    else seq_lim_q = value[SEQ_LIM_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_random_config();
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'($urandom_range(600, MIN_PKT_BYTES)));
    if ($urandom_range(1, 0) == 1) write_cfg(CFG_SEQ_LIMIT, CFG_DATA_W'($urandom_range(64, 1)));
    else write_cfg(CFG_SEQ_LIMIT, CFG_DATA_W'($urandom_range(SEQ_SLOTS, 1)));
  endtask

  task automatic test_directed_cases();
    sender_t s_low;
    sender_t s_high;
    sender_t s_same_ip;
    s_low.ip       = '0;
    s_low.port     = '0;
    s_high.ip      = '1;
    s_high.port    = '1;
    s_same_ip.ip   = sender_pool[0].ip;
    s_same_ip.port = sender_pool[0].port ^ 16'h0001;
    send_idle_pct  = 8;
    recv_idle_pct  = 75;
    send_packet(sender_pool[0], 16, 16, 5, 1'b0, 1'b0, 0);
    send_packet(sender_pool[0], 16, 16, 5, 1'b0, 1'b0, 0);     // duplicate
    send_packet(sender_pool[0], 23, 23, 6, 1'b0, 1'b0, 0);     // partial last word
    send_packet(s_low, 16, 16, 0, 1'b0, 1'b0, 0);
    send_packet(s_high, 15, 15, 1, 1'b0, 1'b0, 0);             // too short
    send_packet(s_high, 3, 3, 0, 1'b0, 1'b0, 0);               // single-word packet
    send_packet(sender_pool[1], 24, 20, 2, 1'b0, 1'b0, 0);     // length mismatch
    send_packet(sender_pool[1], 20, 20, 32'd65536, 1'b0, 1'b0, 0);
    send_packet(sender_pool[1], 20, 20, 32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    send_packet(sender_pool[1], 24, 24, 9, 1'b1, 1'b0, 0);     // payload error
    send_noise_word();
    send_packet(sender_pool[0], 32, 32, 7, 1'b0, 1'b0, 3);     // abandoned by next first word
    send_packet(sender_pool[1], 20, 20, 3, 1'b0, 1'b0, 0);
    send_packet(sender_pool[0], 28, 28, 8, 1'b0, 1'b1, 0);     // ragged valid bytes
    send_packet(s_same_ip, 16, 16, 5, 1'b0, 1'b0, 0);
    wait_all_reports();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'(MIN_PKT_BYTES));
    write_cfg(CFG_SEQ_LIMIT, CFG_DATA_W'(1));
    send_packet(sender_pool[2], 16, 16, 0, 1'b0, 1'b0, 0);
    send_packet(sender_pool[2], 20, 20, 0, 1'b0, 1'b0, 0);
    send_packet(sender_pool[2], 16, 16, 1, 1'b0, 1'b0, 0);
    wait_all_reports();
    // below the minimum size nothing passes
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'(8));
    send_packet(sender_pool[2], 16, 16, 0, 1'b0, 1'b0, 0);
    wait_all_reports();
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'(LEN_MAX));
    write_cfg(CFG_SEQ_LIMIT, CFG_DATA_W'(SEQ_SLOTS));
    send_packet(sender_pool[3], LEN_MAX, LEN_MAX, SEQ_SLOTS - 1, 1'b0, 1'b0, 0);
    send_packet(sender_pool[3], LEN_MAX + 17, LEN_MAX, 4, 1'b0, 1'b0, 0);   // counter saturates
    wait_all_reports();
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'(MAX_LEN_RESET));
  endtask

  task automatic test_backpressure();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 400;
    for (int n = 0; n < 30; n++) begin
      send_packet(sender_pool[$urandom_range(POOL_SIZE - 1, 0)], 16, 16, pick_seq(),
                  1'b0, 1'b0, 0);
    end
    wait_all_reports();
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned tx_idle,
                                     input int unsigned rx_idle, input int unsigned fresh_pct);
    int unsigned stop_at;
    sender_t s;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    stop_at       = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(99, 0) < 3) send_noise_word();
      if ($urandom_range(99, 0) < fresh_pct) s = fresh_sender();
      else s = sender_pool[$urandom_range(POOL_SIZE - 1, 0)];
      send_random_packet(s);
    end
    wait_all_reports();
  endtask

  task automatic test_table_full();
    for (int n = 0; n < POOL_SIZE; n++) begin
      send_packet(sender_pool[n], 20, 20, pick_seq(), 1'b0, 1'b0, 0);
    end
    for (int n = 0; n < 6; n++) begin
      send_packet(fresh_sender(), 16, 16, pick_seq(), 1'b0, 1'b0, 0);
    end
    send_packet(sender_pool[0], 16, 16, pick_seq(), 1'b0, 1'b0, 0);
    wait_all_reports();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    client_ip_i   = '0;
    client_port_i = '0;
    data_word_i   = '0;
    first_word_i  = 1'b0;
    last_word_i   = 1'b0;
    valid_bytes_i = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MAX_LEN;
    cfg_data_i    = '0;
    for (int n = 0; n < POOL_SIZE; n++) sender_pool[n] = fresh_sender();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_config_extremes();
    test_backpressure();
    write_random_config();
    test_random_traffic(420, 8, 75, 0);
    write_random_config();
    test_random_traffic(420, 75, 8, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    write_cfg(CFG_MAX_LEN, CFG_DATA_W'(MAX_LEN_RESET));
    write_cfg(CFG_SEQ_LIMIT, CFG_DATA_W'(SEQ_SLOTS));
    test_random_traffic(420, 0, 0, 10);

    if (expected_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
      mismatches += expected_reports.size();
    end
    $display("Sent %0d packet words, checked %0d reports, %0d mismatches.",
             words_sent, reports_checked, mismatches);
    $display("By status: ok %0d, full %0d, size %0d, len %0d, range %0d, dup %0d, content %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], status_seen[6]);
    if (mismatches == 0) begin
      $display("udp_test_packet_checker regression: pass");
    end else begin
      $display("udp_test_packet_checker regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: run limit reached", $time);
    $display("udp_test_packet_checker regression: fail");
    $finish;
  end

endmodule

/* sim.f */
sv/utpc_pkg.sv
sv/utpc_front.sv
sv/utpc_queue.sv
sv/utpc_back.sv
sv/udp_test_packet_checker.sv
dv/udp_test_packet_checker_test.sv
